[rtl/rmth_pkg.sv]
// Shared types and constants for the running median unit.
`default_nettype none
package rmth_pkg;
    localparam int VALUE_PORT_W = 32;
    localparam int MEDIAN_W     = 33;
    localparam int COUNT_W      = 11;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_REPLACE = 1'b1;

    typedef struct packed {
        logic valid;
        logic op;
    } heap_cmd_t;
endpackage
`default_nettype wire

[rtl/running_median_two_heaps_unit.sv]
// Top level of the running median unit: insertion control and result register.
// Usage:
//   Raise start with a sample on value; the request is taken at a rising edge
//   where start is high and busy is low. Only the low VALUE_WIDTH bits count.
//   One result follows each request: done is high for exactly one cycle with
//   median_x2 (twice the median), element_count and dropped. The receiver
//   cannot stall; a result must be taken in the cycle it is shown.
// Completion: done rises once both heaps' sift engines are idle; each heap level
//   takes a memory read and a compare, and both heaps sift in parallel. A drop
//   starts no sift in either heap.
// Throughput: one request at a time; busy falls as done rises, and the next
//   request can be taken in that cycle.
// Reset: both heaps empty; heap memories need no clearing pass, since only
//   entries below the fill count are read.
// Once CAPACITY samples are held, further samples are discarded and dropped
//   is set, with the median and count of the unchanged set.
`default_nettype none
module running_median_two_heaps_unit #(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                                              clk,
    input  wire                                              rst_n,
    input  wire                                              start,
    output logic                                             busy,
    input  wire  signed [rmth_pkg::VALUE_PORT_W-1:0]         value,
    output logic                                             done,
    output logic signed [rmth_pkg::MEDIAN_W-1:0]             median_x2,
    output logic [rmth_pkg::COUNT_W-1:0]                     element_count,
    output logic                                             dropped
);
    import rmth_pkg::*;

    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = VALUE_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;

    logic [1:0]           state_reg, state_next;
    logic                 drop_reg, drop_next;
    logic                 done_reg;
    logic signed [MEDIAN_W-1:0] med_reg;
    logic [COUNT_W-1:0]   cnt_reg;

    heap_cmd_t            lo_cmd, hi_cmd;
    logic signed [VW-1:0] lo_val, hi_val;
    logic                 lo_busy, hi_busy;
    logic signed [VW-1:0] lo_top, hi_top;
    logic [CW-1:0]        lo_cnt, hi_cnt;

    logic signed [VW-1:0] x;
    logic [CW:0]          total;
    logic signed [MEDIAN_W-1:0] lo_ext, hi_ext, med;
    logic [31:0]          total32;

    rmth_heap #(.DEPTH(DEPTH), .VW(VW), .IS_MIN(1'b0)) u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (lo_cmd),
        .cmd_value (lo_val),
        .busy      (lo_busy),
        .top       (lo_top),
        .count     (lo_cnt)
    );

    rmth_heap #(.DEPTH(DEPTH), .VW(VW), .IS_MIN(1'b1)) u_upper (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (hi_cmd),
        .cmd_value (hi_val),
        .busy      (hi_busy),
        .top       (hi_top),
        .count     (hi_cnt)
    );

    always_comb
    begin
        x       = value[VW-1:0];
        total   = {1'b0, lo_cnt} + {1'b0, hi_cnt};
        total32 = 32'(total);
        lo_ext  = MEDIAN_W'(lo_top);
        hi_ext  = MEDIAN_W'(hi_top);
        if (lo_cnt == hi_cnt)
            med = lo_ext + hi_ext;
        else if (lo_cnt > hi_cnt)
            med = lo_ext <<< 1;
        else
            med = hi_ext <<< 1;
    end

    always_comb
    begin
        state_next = state_reg;
        drop_next  = drop_reg;
        lo_cmd     = '{valid: 1'b0, op: OP_PUSH};
        hi_cmd     = '{valid: 1'b0, op: OP_PUSH};
        lo_val     = x;
        hi_val     = x;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_WAIT;
                    drop_next  = 1'b0;
                    if (32'(total) >= 32'(CAPACITY))
                    begin
                        drop_next = 1'b1;
                    end
                    else if (lo_cnt == hi_cnt)
                    begin
                        if (lo_cnt == '0 || x < lo_top)
                            lo_cmd.valid = 1'b1;
                        else
                            hi_cmd.valid = 1'b1;
                    end
                    else if (lo_cnt > hi_cnt)
                    begin
                        hi_cmd.valid = 1'b1;
                        if (x < lo_top)
                        begin
                            lo_cmd = '{valid: 1'b1, op: OP_REPLACE};
                            hi_val = lo_top;
                        end
                    end
                    else
                    begin
                        lo_cmd.valid = 1'b1;
                        if (x > hi_top)
                        begin
                            hi_cmd = '{valid: 1'b1, op: OP_REPLACE};
                            lo_val = hi_top;
                        end
                    end
                end
            end
            S_WAIT:
            begin
                if (!lo_busy && !hi_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_WAIT) && !lo_busy && !hi_busy;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg <= drop_next;
        if (state_reg == S_WAIT)
        begin
            med_reg <= med;
            cnt_reg <= total32[COUNT_W-1:0];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign median_x2     = med_reg;
    assign element_count = cnt_reg;
    assign dropped       = drop_reg;
endmodule
`default_nettype wire

[rtl/rmth_heap.sv]
// One binary heap held in a synchronous memory, with an insert and a replace-top sift engine.
`default_nettype none
module rmth_heap #(
    parameter int DEPTH  = 512,
    parameter int VW     = 32,
    parameter bit IS_MIN = 1'b0
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire  rmth_pkg::heap_cmd_t           cmd,
    input  wire  signed [VW-1:0]                cmd_value,
    output logic                                busy,
    output logic signed [VW-1:0]                top,
    output logic [$clog2(DEPTH+1)-1:0]          count
);
    import rmth_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_URD  = 3'd1;
    localparam logic [2:0] H_UCMP = 3'd2;
    localparam logic [2:0] H_DRD  = 3'd3;
    localparam logic [2:0] H_DCMP = 3'd4;

    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] rd0_reg, rd1_reg;

    logic [2:0]           state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic signed [VW-1:0] val_reg, val_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [VW-1:0] top_reg;

    logic                 we;
    logic [AW-1:0]        wa, ra0, ra1;
    logic signed [VW-1:0] wd;

    logic [IW:0]          child, child1, cnt_ext;
    logic [IW-1:0]        parent;
    logic                 take1;

    function automatic logic better(input logic signed [VW-1:0] a,
                                    input logic signed [VW-1:0] b);
        logic r;
        if (IS_MIN)
            r = a < b;
        else
            r = a > b;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    always_comb
    begin
        child   = {idx_reg, 1'b1};
        child1  = child + {{IW{1'b0}}, 1'b1};
        cnt_ext = {{(IW + 1 - CW){1'b0}}, count_reg};
        parent  = (idx_reg - {{(IW-1){1'b0}}, 1'b1}) >> 1;
        take1   = (child1 < cnt_ext) && better(rd1_reg, rd0_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        count_next = count_reg;
        we         = 1'b0;
        wa         = idx_reg[AW-1:0];
        wd         = val_reg;
        ra0        = parent[AW-1:0];
        ra1        = child1[AW-1:0];
        case (state_reg)
            H_IDLE:
            begin
                if (cmd.valid)
                begin
                    val_next = cmd_value;
                    if (cmd.op == OP_PUSH)
                    begin
                        idx_next   = {1'b0, count_reg};
                        count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                        state_next = H_URD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = H_DRD;
                    end
                end
            end
            H_URD:
            begin
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    state_next = H_UCMP;
                end
            end
            H_UCMP:
            begin
                we = 1'b1;
                if (!better(val_reg, rd0_reg))
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    wd         = rd0_reg;
                    idx_next   = parent;
                    state_next = H_URD;
                end
            end
            H_DRD:
            begin
                ra0 = child[AW-1:0];
                if (child >= cnt_ext)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    state_next = H_DCMP;
                end
            end
            H_DCMP:
            begin
                we = 1'b1;
                if (!better(take1 ? rd1_reg : rd0_reg, val_reg))
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    wd         = take1 ? rd1_reg : rd0_reg;
                    idx_next   = take1 ? child1[IW-1:0] : child[IW-1:0];
                    state_next = H_DRD;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        if (we && wa == '0)
        begin
            top_reg <= wd;
        end
    end

    assign busy  = (state_reg != H_IDLE);
    assign top   = top_reg;
    assign count = count_reg;
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the running median unit: self-predicting two-heap median checks.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP   = 1024;
    localparam int HALF  = (CAP + 1) / 2;
    localparam int LOWER = 0;
    localparam int UPPER = 1;

    typedef struct {
        logic signed [rmth_pkg::MEDIAN_W-1:0] median;
        logic [rmth_pkg::COUNT_W-1:0]         count;
        logic                                 full;
    } median_result_t;

    logic                                     clk = 1'b0;
    logic                                     rst_n = 1'b0;
    logic                                     start = 1'b0;
    logic signed [rmth_pkg::VALUE_PORT_W-1:0] value = '0;
    wire                                      busy;
    wire                                      done;
    wire signed [rmth_pkg::MEDIAN_W-1:0]      median_x2;
    wire [rmth_pkg::COUNT_W-1:0]              element_count;
    wire                                      dropped;

    median_result_t median_q[$];
    longint         heap_mem[2][HALF];
    int             heap_fill[2];
    int             errors = 0;
    int             idle_pct = 0;

    running_median_two_heaps_unit #(.CAPACITY(CAP), .VALUE_WIDTH(32)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .value(value),
        .done(done), .median_x2(median_x2), .element_count(element_count),
        .dropped(dropped)
    );

    always #5 clk = ~clk;

    // both heaps are max-heaps; the upper one holds negated samples
    function automatic void heap_add(int h, longint v);
        int i;
        int p;
        i = heap_fill[h];
        heap_fill[h]++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (heap_mem[h][p] >= v)
                break;
            heap_mem[h][i] = heap_mem[h][p];
            i = p;
        end
        heap_mem[h][i] = v;
    endfunction

    function automatic longint heap_take(int h);
        longint top;
        longint last;
        int     i;
        int     c;
        int     n;
        i = 0;
        top = heap_mem[h][0];
        heap_fill[h]--;
        n = heap_fill[h];
        last = heap_mem[h][n];
        forever
        begin
            c = 2 * i + 1;
            if (c >= n)
                break;
            if (c + 1 < n && heap_mem[h][c + 1] > heap_mem[h][c])
                c++;
            if (heap_mem[h][c] <= last)
                break;
            heap_mem[h][i] = heap_mem[h][c];
            i = c;
        end
        if (n > 0)
            heap_mem[h][i] = last;
        return top;
    endfunction

    function automatic median_result_t median_insert(logic signed [31:0] sample);
        median_result_t r;
        longint x;
        longint lo;
        longint hi;
        longint m;
        x = longint'(sample);
        r.full = 1'b0;
        if (heap_fill[LOWER] + heap_fill[UPPER] >= CAP)
            r.full = 1'b1;
        else if (heap_fill[LOWER] == heap_fill[UPPER])
        begin
            if (heap_fill[LOWER] == 0 || x < heap_mem[LOWER][0])
                heap_add(LOWER, x);
            else
                heap_add(UPPER, -x);
        end
        else if (heap_fill[LOWER] > heap_fill[UPPER])
        begin
            if (x >= heap_mem[LOWER][0])
                heap_add(UPPER, -x);
            else
            begin
                heap_add(UPPER, -heap_take(LOWER));
                heap_add(LOWER, x);
            end
        end
        else
        begin
            if (x <= -heap_mem[UPPER][0])
                heap_add(LOWER, x);
            else
            begin
                heap_add(LOWER, -heap_take(UPPER));
                heap_add(UPPER, -x);
            end
        end
        lo = heap_fill[LOWER] != 0 ? heap_mem[LOWER][0] : 0;
        hi = heap_fill[UPPER] != 0 ? -heap_mem[UPPER][0] : 0;
        if (heap_fill[LOWER] == heap_fill[UPPER])
            m = lo + hi;
        else if (heap_fill[LOWER] > heap_fill[UPPER])
            m = 2 * lo;
        else
            m = 2 * hi;
        r.median = m[rmth_pkg::MEDIAN_W-1:0];
        r.count = 11'(heap_fill[LOWER] + heap_fill[UPPER]);
        return r;
    endfunction

    // start is left high on return; idle cycles may be inserted before a request
    task automatic send_sample(logic signed [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        median_q.push_back(median_insert(v));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (median_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $signed(32'($urandom_range(20))) - 10;
            1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        median_result_t e;
        if (rst_n && done)
        begin
            if (median_q.size() == 0)
            begin
                $display("%0t: result with no request pending: median_x2 %0d", $time,
                         median_x2);
                errors++;
            end
            else
            begin
                e = median_q.pop_front();
                if (median_x2 !== e.median)
                begin
                    $display("%0t: median_x2 expected %0d got %0d", $time, e.median,
                             median_x2);
                    errors++;
                end
                if (element_count !== e.count)
                begin
                    $display("%0t: element_count expected %0d got %0d", $time, e.count,
                             element_count);
                    errors++;
                end
                if (dropped !== e.full)
                begin
                    $display("%0t: dropped expected %0b got %0b", $time, e.full, dropped);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        idle_pct = 0;
        send_sample(32'sh80000000);
        send_sample(32'sh7fffffff);
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(32'sh80000000);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(1);
        send_sample(1);
        send_sample(-5);
        send_sample(-5);
        send_sample(100);
        send_sample(-100);
        send_sample(32'sh55555555);
        send_sample(32'shaaaaaaaa);
        send_sample(0);
        send_sample(0);
        drain_results();
    endtask

    task automatic test_random(int sender_idle, int n);
        idle_pct = sender_idle;
        repeat (n)
            send_sample(rand_sample());
    endtask

    task automatic test_pause();
        drain_results();
        repeat ($urandom_range(5, 20))
            @(posedge clk);
        idle_pct = 0;
        repeat (10)
            send_sample(rand_sample());
    endtask

    task automatic test_full_set();
        idle_pct = 0;
        while (heap_fill[LOWER] + heap_fill[UPPER] < CAP)
            send_sample(rand_sample());
        idle_pct = 32;
        send_sample(32'sh80000000);
        send_sample(32'sh7fffffff);
        send_sample(0);
        repeat (12)
            send_sample(rand_sample());
    endtask

    initial
    begin
        heap_fill[LOWER] = 0;
        heap_fill[UPPER] = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 180);
        test_random(75, 170);
        test_pause();
        test_random(0, 150);
        test_random(32, 170);
        test_full_set();
        drain_results();
        repeat (40)
            @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
